>>> design/rwag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwag_pkg
// Shared types and constants of the ripple warp address generator.
// ----------------------------------------------------------------------------
package rwag_pkg;

  localparam int CW     = 12;          // coordinate width
  localparam int SQ_W   = 2 * CW + 1;  // squared distance
  localparam int ROOT_W = CW + 1;      // radius
  localparam int A_W    = ROOT_W + 1;  // radius plus phase
  localparam int WL_W   = 9;
  localparam int AMP_W  = 6;
  localparam int PH_W   = 8;
  localparam int RL_W   = 13;
  localparam int IDX_W  = 8;
  localparam int VAL_W  = 16;

  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [2:0] {
    CFG_POOL_POS  = 3'd0,
    CFG_POOL_SIZE = 3'd1,
    CFG_ORIGIN    = 3'd2,
    CFG_WAVE_LEN  = 3'd3,
    CFG_AMPLITUDE = 3'd4,
    CFG_PHASE     = 3'd5,
    CFG_RADIUS    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic             is_load;
    logic [CW-1:0]    row;
    logic [CW-1:0]    col;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             in_pool;
    logic             ripple;
  } item_t;

  typedef struct packed {
    logic [CW-1:0]    px;
    logic [CW-1:0]    py;
    logic [CW-1:0]    pw;
    logic [CW-1:0]    ph;
    logic [CW-1:0]    ox;
    logic [CW-1:0]    oy;
    logic [WL_W-1:0]  wl;     // already clamped
    logic [AMP_W-1:0] amp;
    logic [PH_W-1:0]  phase;
    logic [RL_W-1:0]  rlim;
  } cfg_t;

endpackage

>>> design/rwag_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwag_front
// Pool test, distance to origin, squares and squared-distance sum.
// ----------------------------------------------------------------------------
module rwag_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  rwag_pkg::item_t           item_i,
  input  rwag_pkg::cfg_t            cfg_i,
  output logic                      valid_o,
  output rwag_pkg::item_t           item_o,
  output logic [rwag_pkg::SQ_W-1:0] sq_o
);
  localparam int CW = rwag_pkg::CW;

  logic                   in_pool;
  logic signed [CW:0]     dy_d, dx_d;
  rwag_pkg::item_t        it_d;

  logic                   va_q, vb_q, vc_q;
  rwag_pkg::item_t        ita_q, itb_q, itc_q;
  logic signed [CW:0]     dy_q, dx_q;
  logic signed [2*CW+1:0] sqy_full, sqx_full;
  logic [2*CW-1:0]        sqy_q, sqx_q;
  logic [rwag_pkg::SQ_W-1:0] sum_q;

  assign in_pool = ({1'b0, item_i.row} >= {1'b0, cfg_i.py}) &&
                   ({1'b0, item_i.row} <  ({1'b0, cfg_i.py} + {1'b0, cfg_i.ph})) &&
                   ({1'b0, item_i.col} >= {1'b0, cfg_i.px}) &&
                   ({1'b0, item_i.col} <  ({1'b0, cfg_i.px} + {1'b0, cfg_i.pw}));
  assign dy_d = $signed({1'b0, item_i.row}) - $signed({1'b0, cfg_i.oy});
  assign dx_d = $signed({1'b0, item_i.col}) - $signed({1'b0, cfg_i.ox});

  always_comb begin
    it_d         = item_i;
    it_d.in_pool = in_pool;
    it_d.ripple  = 1'b0;
  end

  assign sqy_full = dy_q * dy_q;
  assign sqx_full = dx_q * dx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ita_q <= it_d;
      dy_q  <= dy_d;
      dx_q  <= dx_d;
      itb_q <= ita_q;
      sqy_q <= sqy_full[2*CW-1:0];
      sqx_q <= sqx_full[2*CW-1:0];
      itc_q <= itb_q;
      sum_q <= {1'b0, sqy_q} + {1'b0, sqx_q};
    end
  end

  assign valid_o = vc_q;
  assign item_o  = itc_q;
  assign sq_o    = sum_q;

endmodule

>>> design/rwag_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwag_isqrt
// Pipelined floor square root, two radicand bits per step, four steps a stage.
// ----------------------------------------------------------------------------
module rwag_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  rwag_pkg::item_t             item_i,
  input  logic [rwag_pkg::SQ_W-1:0]   sq_i,
  output logic                        valid_o,
  output rwag_pkg::item_t             item_o,
  output logic [rwag_pkg::ROOT_W-1:0] root_o
);
  localparam int SPS   = 4;
  localparam int NST   = (rwag_pkg::ROOT_W + SPS - 1) / SPS;
  localparam int RT_W  = NST * SPS;
  localparam int PAD_W = 2 * RT_W;
  localparam int REM_W = RT_W + 3;

  logic                 v_q    [NST];
  rwag_pkg::item_t      it_q   [NST];
  logic [REM_W-1:0]     rem_q  [NST];
  logic [RT_W-1:0]      root_q [NST];
  logic [PAD_W-1:0]     rad_q  [NST];

  logic                 v_in    [NST];
  rwag_pkg::item_t      it_in   [NST];
  logic [REM_W-1:0]     rem_in  [NST];
  logic [RT_W-1:0]      root_in [NST];
  logic [PAD_W-1:0]     rad_in  [NST];
  logic [REM_W-1:0]     rem_d   [NST];
  logic [RT_W-1:0]      root_d  [NST];
  logic [PAD_W-1:0]     rad_d   [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    if (s == 0) begin : g_first
      assign v_in[s]    = valid_i;
      assign it_in[s]   = item_i;
      assign rem_in[s]  = '0;
      assign root_in[s] = '0;
      assign rad_in[s]  = {{(PAD_W - rwag_pkg::SQ_W){1'b0}}, sq_i};
    end else begin : g_next
      assign v_in[s]    = v_q[s-1];
      assign it_in[s]   = it_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign root_in[s] = root_q[s-1];
      assign rad_in[s]  = rad_q[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] rem;
      logic [REM_W-1:0] trial;
      logic [RT_W-1:0]  root;
      logic [PAD_W-1:0] rad;
      rem  = rem_in[s];
      root = root_in[s];
      rad  = rad_in[s];
      for (int k = 0; k < SPS; k++) begin
        rem   = {rem[REM_W-3:0], rad[PAD_W-1 -: 2]};
        rad   = {rad[PAD_W-3:0], 2'b00};
        trial = {1'b0, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[RT_W-2:0], 1'b1};
        end else begin
          root = {root[RT_W-2:0], 1'b0};
        end
      end
      rem_d[s]  = rem;
      root_d[s] = root;
      rad_d[s]  = rad;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv_i) begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        it_q[s]   <= it_in[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        rad_q[s]  <= rad_d[s];
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign item_o  = it_q[NST-1];
  assign root_o  = root_q[NST-1][rwag_pkg::ROOT_W-1:0];

endmodule

>>> design/rwag_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwag_mod
// Pipelined restoring remainder of (radius + phase) by the wave length.
// ----------------------------------------------------------------------------
module rwag_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  rwag_pkg::item_t           item_i,
  input  logic [rwag_pkg::A_W-1:0]  a_i,
  input  logic [rwag_pkg::WL_W-1:0] wl_i,
  output logic                      valid_o,
  output rwag_pkg::item_t           item_o,
  output logic [rwag_pkg::WL_W-1:0] m_o
);
  localparam int SPS   = 4;
  localparam int NST   = (rwag_pkg::A_W + SPS - 1) / SPS;
  localparam int PAD_W = NST * SPS;
  localparam int WL_W  = rwag_pkg::WL_W;

  logic              v_q   [NST];
  rwag_pkg::item_t   it_q  [NST];
  logic [WL_W-1:0]   rem_q [NST];
  logic [PAD_W-1:0]  num_q [NST];

  logic              v_in   [NST];
  rwag_pkg::item_t   it_in  [NST];
  logic [WL_W-1:0]   rem_in [NST];
  logic [PAD_W-1:0]  num_in [NST];
  logic [WL_W-1:0]   rem_d  [NST];
  logic [PAD_W-1:0]  num_d  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    if (s == 0) begin : g_first
      assign v_in[s]   = valid_i;
      assign it_in[s]  = item_i;
      assign rem_in[s] = '0;
      assign num_in[s] = {{(PAD_W - rwag_pkg::A_W){1'b0}}, a_i};
    end else begin : g_next
      assign v_in[s]   = v_q[s-1];
      assign it_in[s]  = it_q[s-1];
      assign rem_in[s] = rem_q[s-1];
      assign num_in[s] = num_q[s-1];
    end

    always_comb begin
      logic [WL_W:0]    t;
      logic [WL_W-1:0]  rem;
      logic [PAD_W-1:0] num;
      rem = rem_in[s];
      num = num_in[s];
      for (int k = 0; k < SPS; k++) begin
        t   = {rem, num[PAD_W-1]};
        num = {num[PAD_W-2:0], 1'b0};
        if (t >= {1'b0, wl_i}) begin
          t = t - {1'b0, wl_i};
        end
        rem = t[WL_W-1:0];
      end
      rem_d[s] = rem;
      num_d[s] = num;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv_i) begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        it_q[s]  <= it_in[s];
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign item_o  = it_q[NST-1];
  assign m_o     = rem_q[NST-1];

endmodule

>>> design/rwag_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwag_offset
// Sine table, amplitude scaling, displaced point check and output register.
// ----------------------------------------------------------------------------
module rwag_offset #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  rwag_pkg::item_t           item_i,
  input  logic [rwag_pkg::WL_W-1:0] m_i,
  input  rwag_pkg::cfg_t            cfg_i,
  output logic                      valid_o,
  output logic [rwag_pkg::CW-1:0]   src_row_o,
  output logic [rwag_pkg::CW-1:0]   src_col_o,
  output logic                      displaced_o
);
  localparam int CW     = rwag_pkg::CW;
  localparam int WL_W   = rwag_pkg::WL_W;
  localparam int VAL_W  = rwag_pkg::VAL_W;
  localparam int TIDX_W = $clog2(TABLE_DEPTH);
  localparam int P_W    = VAL_W + rwag_pkg::AMP_W + 1;
  localparam int OFF_W  = P_W - 14 + 1;

  logic [VAL_W-1:0] sine_mem [TABLE_DEPTH];

  // read stage
  logic [WL_W:0]     m2_sum, m2;
  logic [TIDX_W-1:0] iy, ix;
  logic              wr_en;
  logic              vr_q;
  rwag_pkg::item_t   itr_q;
  logic [VAL_W-1:0]  ey_q, ex_q;

  // multiply stage
  logic              vm_q;
  rwag_pkg::item_t   itm_q;
  logic signed [P_W-1:0] py_q, px_q;

  // offset stage
  logic [P_W-1:0]    magy, magx;
  logic signed [OFF_W-1:0] offy_d, offx_d;
  logic              vf_q;
  rwag_pkg::item_t   itf_q;
  logic signed [OFF_W-1:0] offy_q, offx_q;

  // output stage
  logic signed [CW+1:0] nr, nc;
  logic              r_ok, c_ok;
  logic              out_v_q, disp_q;
  logic [CW-1:0]     srow_q, scol_q;

  assign m2_sum = {1'b0, m_i} + {2'b00, cfg_i.wl[WL_W-1:1]};
  assign m2     = (m2_sum >= {1'b0, cfg_i.wl}) ? (m2_sum - {1'b0, cfg_i.wl}) : m2_sum;
  assign iy     = m_i[TIDX_W-1:0];
  assign ix     = m2[TIDX_W-1:0];
  assign wr_en  = adv_i && valid_i && (item_i.is_load == rwag_pkg::REQ_LOAD) &&
                  ({1'b0, item_i.idx} < (rwag_pkg::IDX_W + 1)'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sine_mem[item_i.idx[TIDX_W-1:0]] <= item_i.val;
    end
    if (adv_i) begin
      ey_q <= sine_mem[iy];
      ex_q <= sine_mem[ix];
    end
  end

  // truncate toward zero: scale the magnitude and restore the sign
  assign magy   = py_q[P_W-1] ? P_W'(-py_q) : P_W'(py_q);
  assign magx   = px_q[P_W-1] ? P_W'(-px_q) : P_W'(px_q);
  assign offy_d = py_q[P_W-1] ? -$signed({1'b0, magy[P_W-1:14]}) : $signed({1'b0, magy[P_W-1:14]});
  assign offx_d = px_q[P_W-1] ? -$signed({1'b0, magx[P_W-1:14]}) : $signed({1'b0, magx[P_W-1:14]});

  assign nr = $signed({2'b00, itf_q.row}) + (CW + 2)'(offy_q);
  assign nc = $signed({2'b00, itf_q.col}) + (CW + 2)'(offx_q);
  assign r_ok = (nr[CW+1:CW] == 2'b00) &&
                ({1'b0, nr[CW-1:0]} >= {1'b0, cfg_i.py}) &&
                ({1'b0, nr[CW-1:0]} <  ({1'b0, cfg_i.py} + {1'b0, cfg_i.ph}));
  assign c_ok = (nc[CW+1:CW] == 2'b00) &&
                ({1'b0, nc[CW-1:0]} >= {1'b0, cfg_i.px}) &&
                ({1'b0, nc[CW-1:0]} <  ({1'b0, cfg_i.px} + {1'b0, cfg_i.pw}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q    <= 1'b0;
      vm_q    <= 1'b0;
      vf_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv_i) begin
      vr_q    <= valid_i && (item_i.is_load != rwag_pkg::REQ_LOAD);
      vm_q    <= vr_q;
      vf_q    <= vm_q;
      out_v_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      itr_q  <= item_i;
      itm_q  <= itr_q;
      py_q   <= $signed(ey_q) * $signed({1'b0, cfg_i.amp});
      px_q   <= $signed(ex_q) * $signed({1'b0, cfg_i.amp});
      itf_q  <= itm_q;
      offy_q <= offy_d;
      offx_q <= offx_d;
      if (itf_q.ripple && r_ok && c_ok) begin
        srow_q <= nr[CW-1:0];
        scol_q <= nc[CW-1:0];
        disp_q <= 1'b1;
      end else begin
        srow_q <= itf_q.row;
        scol_q <= itf_q.col;
        disp_q <= 1'b0;
      end
    end
  end

  assign valid_o     = out_v_q;
  assign src_row_o   = srow_q;
  assign src_col_o   = scol_q;
  assign displaced_o = disp_q;

endmodule

>>> design/ripple_warp_address_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ripple_warp_address_gen
// Source address generator for a radial ripple warp, with a loadable sine
// table. Queries return one result beat; table loads return none.
// ----------------------------------------------------------------------------
//  port group   dir  tdata (low bit up)                        tuser
//  s_axis       in   pixel_row, pixel_col, table_index, value  req_type
//  m_axis       out  src_row, src_col                          displaced
//  cfg          in   cfg_we_i / cfg_idx_i / cfg_wdata_i, no read-back
//
//  One beat per cycle in and out while m_axis is ready. Stages, in order:
//  distance squares, square root (4 bits a stage), wave length remainder,
//  then table read, scaling, offset and check.
//  A stalled output holds the whole pipeline; nothing is dropped or repeated.
//  Reset clears valids and resets config; the sine table is undefined until loaded.
// ----------------------------------------------------------------------------
module ripple_warp_address_gen #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // pixel_row, pixel_col, table_index, table_value
  input  logic        s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // src_row, src_col
  output logic        m_axis_tuser_o,   // displaced
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);
  localparam int CW   = rwag_pkg::CW;
  localparam int WL_W = rwag_pkg::WL_W;

  // configuration registers
  logic [2*CW-1:0]              pool_pos_q, pool_size_q, origin_q;
  logic [WL_W-1:0]              wave_len_q;
  logic [rwag_pkg::AMP_W-1:0]   amp_q;
  logic [rwag_pkg::PH_W-1:0]    phase_q;
  logic [rwag_pkg::RL_W-1:0]    rlim_q;
  logic [WL_W-1:0]              wl_sat;
  rwag_pkg::cfg_t               cfg;

  // pipeline
  logic                         adv;
  rwag_pkg::item_t              in_item;
  logic                         fr_v, sq_v, md_v, out_v;
  rwag_pkg::item_t              fr_it, sq_it, md_it, md_in_it;
  logic [rwag_pkg::SQ_W-1:0]    fr_sq;
  logic [rwag_pkg::ROOT_W-1:0]  root;
  logic [rwag_pkg::A_W-1:0]     a_sum;
  logic [WL_W-1:0]              md_m;
  logic [CW-1:0]                src_row, src_col;
  logic                         disp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_pos_q  <= '0;
      pool_size_q <= '0;
      origin_q    <= '0;
      wave_len_q  <= WL_W'(12);
      amp_q       <= rwag_pkg::AMP_W'(4);
      phase_q     <= '0;
      rlim_q      <= rwag_pkg::RL_W'(5793);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rwag_pkg::CFG_POOL_POS:  pool_pos_q  <= cfg_wdata_i;
        rwag_pkg::CFG_POOL_SIZE: pool_size_q <= cfg_wdata_i;
        rwag_pkg::CFG_ORIGIN:    origin_q    <= cfg_wdata_i;
        rwag_pkg::CFG_WAVE_LEN:  wave_len_q  <= cfg_wdata_i[WL_W-1:0];
        rwag_pkg::CFG_AMPLITUDE: amp_q       <= cfg_wdata_i[rwag_pkg::AMP_W-1:0];
        rwag_pkg::CFG_PHASE:     phase_q     <= cfg_wdata_i[rwag_pkg::PH_W-1:0];
        rwag_pkg::CFG_RADIUS:    rlim_q      <= cfg_wdata_i[rwag_pkg::RL_W-1:0];
        default: ;
      endcase
    end
  end

  // wave length clamped into 4..TABLE_DEPTH
  assign wl_sat = (wave_len_q < WL_W'(4))           ? WL_W'(4) :
                  (wave_len_q > WL_W'(TABLE_DEPTH)) ? WL_W'(TABLE_DEPTH) : wave_len_q;

  always_comb begin
    cfg.px    = pool_pos_q[CW-1:0];
    cfg.py    = pool_pos_q[2*CW-1:CW];
    cfg.pw    = pool_size_q[CW-1:0];
    cfg.ph    = pool_size_q[2*CW-1:CW];
    cfg.ox    = origin_q[CW-1:0];
    cfg.oy    = origin_q[2*CW-1:CW];
    cfg.wl    = wl_sat;
    cfg.amp   = amp_q;
    cfg.phase = phase_q;
    cfg.rlim  = rlim_q;
  end

  // whole pipeline moves unless the output beat is held
  assign adv             = !out_v || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_comb begin
    in_item.is_load = s_axis_tuser_i;
    in_item.row     = s_axis_tdata_i[11:0];
    in_item.col     = s_axis_tdata_i[23:12];
    in_item.idx     = s_axis_tdata_i[31:24];
    in_item.val     = s_axis_tdata_i[47:32];
    in_item.in_pool = 1'b0;
    in_item.ripple  = 1'b0;
  end

  rwag_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_axis_tvalid_i),
    .item_i  (in_item),
    .cfg_i   (cfg),
    .valid_o (fr_v),
    .item_o  (fr_it),
    .sq_o    (fr_sq)
  );

  rwag_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fr_v),
    .item_i  (fr_it),
    .sq_i    (fr_sq),
    .valid_o (sq_v),
    .item_o  (sq_it),
    .root_o  (root)
  );

  // ripple applies for 1 <= r < radius_limit inside the pool
  always_comb begin
    md_in_it        = sq_it;
    md_in_it.ripple = sq_it.in_pool && (root != '0) && (root < rlim_q);
  end
  assign a_sum = {1'b0, root} + rwag_pkg::A_W'(phase_q);

  rwag_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sq_v),
    .item_i  (md_in_it),
    .a_i     (a_sum),
    .wl_i    (wl_sat),
    .valid_o (md_v),
    .item_o  (md_it),
    .m_o     (md_m)
  );

  rwag_offset #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (md_v),
    .item_i      (md_it),
    .m_i         (md_m),
    .cfg_i       (cfg),
    .valid_o     (out_v),
    .src_row_o   (src_row),
    .src_col_o   (src_col),
    .displaced_o (disp)
  );

  assign m_axis_tvalid_o = out_v;
  assign m_axis_tdata_o  = {src_col, src_row};
  assign m_axis_tuser_o  = disp;

  // a held output beat must block intake
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  // a displaced source always lies inside the pool rectangle
  a_disp_row_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      ({1'b0, src_row} >= {1'b0, cfg.py}) &&
      ({1'b0, src_row} < ({1'b0, cfg.py} + {1'b0, cfg.ph})))
    else $error("displaced row outside pool");

  a_disp_col_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      ({1'b0, src_col} >= {1'b0, cfg.px}) &&
      ({1'b0, src_col} < ({1'b0, cfg.px} + {1'b0, cfg.pw})))
    else $error("displaced column outside pool");

endmodule
